>>> hw/rtl/crcfe_pkg.sv
// Shared types, byte codes and the CRC-16 byte update for the frame encoder.
// No dependencies.
package crcfe_pkg;

    localparam logic [7:0]  START_BYTE = 8'h1F;
    localparam logic [7:0]  ESC_BYTE   = 8'h2F;
    localparam logic [7:0]  END_BYTE   = 8'h55;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Output sequence positions for one payload byte.
    typedef enum logic [3:0] {
        PH_START,
        PH_DATA,
        PH_DATA2,
        PH_CRCL,
        PH_CRCL2,
        PH_CRCH,
        PH_CRCH2,
        PH_ESC,
        PH_END
    } phase_t;

    // One accepted payload byte with what is needed to emit its output bytes.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        first;   // opens a frame: start byte goes first
        logic [15:0] crc;     // CRC including this byte
    } item_t;

    function automatic logic needs_stuff(input logic [7:0] b);
        return (b == START_BYTE) || (b == ESC_BYTE);
    endfunction

    // MSB-first CRC-16 update, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crcfe_emitter.sv
// Output sequencer: walks the output bytes of one held item into the master register.
// Depends on crcfe_pkg.
module crcfe_emitter import crcfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_done,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // out_last
);

    phase_t     phase_reg, phase_next, cur;
    logic       out_free;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = item_valid && out_free;
    // Continuation bytes of an open frame skip the start byte.
    assign cur = (phase_reg == PH_START && !item.first) ? PH_DATA : phase_reg;

    // next state
    always_comb begin
        phase_next = phase_reg;
        item_done  = 1'b0;
        if (emit) begin
            case (cur)
                PH_START: phase_next = PH_DATA;
                PH_DATA: begin
                    if (needs_stuff(item.data)) begin
                        phase_next = PH_DATA2;
                    end else if (item.last) begin
                        phase_next = PH_CRCL;
                    end else begin
                        phase_next = PH_START;
                        item_done  = 1'b1;
                    end
                end
                PH_DATA2: begin
                    if (item.last) begin
                        phase_next = PH_CRCL;
                    end else begin
                        phase_next = PH_START;
                        item_done  = 1'b1;
                    end
                end
                PH_CRCL:  phase_next = needs_stuff(item.crc[7:0]) ? PH_CRCL2 : PH_CRCH;
                PH_CRCL2: phase_next = PH_CRCH;
                PH_CRCH:  phase_next = needs_stuff(item.crc[15:8]) ? PH_CRCH2 : PH_ESC;
                PH_CRCH2: phase_next = PH_ESC;
                PH_ESC:   phase_next = PH_END;
                PH_END: begin
                    phase_next = PH_START;
                    item_done  = 1'b1;
                end
                default: phase_next = PH_START;
            endcase
        end
    end

    // outputs
    always_comb begin
        emit_last = 1'b0;
        case (cur)
            PH_START:            emit_byte = START_BYTE;
            PH_DATA, PH_DATA2:   emit_byte = item.data;
            PH_CRCL, PH_CRCL2:   emit_byte = item.crc[7:0];
            PH_CRCH, PH_CRCH2:   emit_byte = item.crc[15:8];
            PH_ESC:              emit_byte = ESC_BYTE;
            PH_END: begin
                emit_byte = END_BYTE;
                emit_last = 1'b1;
            end
            default:             emit_byte = START_BYTE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (out_free) begin
                m_tvalid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= emit_byte;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hw/rtl/crc16_byte_stuffed_frame_encoder.sv
// Top level of the CRC-16 byte-stuffed frame encoder: input register, CRC state, emitter.
// Depends on crcfe_pkg and crcfe_emitter.
//
// Payload bytes come in on the slave stream (tlast marks the final byte of a frame) and
// leave as a framed stream: start byte 0x1F, the payload with 0x1F/0x2F doubled, the
// CRC-16 (poly 0x1021, init 0, MSB first) low then high byte, stuffed the same way, and
// the trailer 0x2F 0x55, with m_tlast on the 0x55. The master side moves one byte per
// cycle while m_tready is high. An input beat produces 1 output byte for a plain byte
// inside a frame, 2 for a stuffed one, plus 1 for the start byte of a frame and 4 to 6
// for the CRC and trailer after the last byte (9 at most), all from the output
// sequencer; the CRC is updated in the cycle a beat is accepted, and the next beat is
// taken in the same cycle the previous beat's final byte enters the output register.
module crc16_byte_stuffed_frame_encoder import crcfe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    logic        item_valid_reg;
    item_t       item_reg;
    logic        item_done;
    logic        s_accept;
    logic [15:0] crc_reg, crc_new;
    logic        in_frame_reg;

    assign s_tready = !item_valid_reg || item_done;
    assign s_accept = s_tvalid && s_tready;
    assign crc_new  = crc_feed(in_frame_reg ? crc_reg : 16'h0000, s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            crc_reg        <= 16'h0000;
            in_frame_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                item_valid_reg <= 1'b1;
                crc_reg        <= s_tlast ? 16'h0000 : crc_new;
                in_frame_reg   <= !s_tlast;
            end else if (item_done) begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.data  <= s_tdata;
            item_reg.last  <= s_tlast;
            item_reg.first <= !in_frame_reg;
            item_reg.crc   <= crc_new;
        end
    end

    crcfe_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .item_done  (item_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> hw/rtl/crcfe_checker.sv
// Port-level checks for the frame encoder, bound to the top level.
// Depends on crcfe_pkg and crc16_byte_stuffed_frame_encoder.
module crcfe_checker import crcfe_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic       m_beat;
    logic [7:0] prev_byte_reg;
    logic       after_end_reg;   // next master beat opens a frame

    assign m_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg <= 8'h00;
            after_end_reg <= 1'b1;
        end else if (m_beat) begin
            prev_byte_reg <= m_tdata;
            after_end_reg <= m_tlast;
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("stalled input beat changed");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == END_BYTE)
        else $error("tlast on a byte other than the end byte");

    a_end_after_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && m_tlast |-> prev_byte_reg == ESC_BYTE)
        else $error("end byte not preceded by escape byte");

    a_frame_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && after_end_reg |-> m_tdata == START_BYTE && !m_tlast)
        else $error("frame does not open with start byte");

endmodule

bind crc16_byte_stuffed_frame_encoder crcfe_checker u_crcfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/sv/crc16_byte_stuffed_frame_encoder_test.sv
// Self-checking testbench for crc16_byte_stuffed_frame_encoder: queued stream driver,
// output monitor with an in-line frame predictor, random idling and a long sink stall.
// Depends on crcfe_pkg and the encoder RTL.
module crc16_byte_stuffed_frame_encoder_test import crcfe_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PCT      = 22;
    localparam int TARGET_BEATS  = 280;
    localparam int STALL_CYCLES  = 200;
    localparam int STALL_AT_BYTE = 450;
    localparam int DRAIN_CYCLES  = 20;
    localparam int WATCHDOG_MAX  = 2000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } payload_beat_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } framed_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] data_byte
    logic       s_tlast  = 1'b0; // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] out_byte
    logic       m_tlast;         // out_last

    crc16_byte_stuffed_frame_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    int rst_cycles = 0;
    always @(posedge aclk) begin
        if (rst_cycles < RESET_CYCLES) begin
            rst_cycles <= rst_cycles + 1;
            aresetn    <= 1'b0;
        end else begin
            aresetn <= 1'b1;
        end
    end

    // ---------------- predictor ----------------
    payload_beat_t pending_beats[$];
    framed_byte_t  framed_bytes[$];
    logic [15:0]   crc_acc    = '0;
    logic          frame_open = 1'b0;
    int            frames_sent  = 0;
    int            stuffed_seen = 0;
    int            beats_sent   = 0;
    int            bytes_rx     = 0;
    int            errors       = 0;

    // bitwise LFSR form of the CRC-16 byte update
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic push_out(input logic [7:0] d, input logic l);
        framed_byte_t fb;
        fb.data = d;
        fb.last = l;
        framed_bytes.push_back(fb);
    endtask

    task automatic push_stuffed(input logic [7:0] d);
        push_out(d, 1'b0);
        if (d == START_BYTE || d == ESC_BYTE) begin
            push_out(d, 1'b0);
            stuffed_seen++;
        end
    endtask

    task automatic frame_encode(input logic [7:0] d, input logic l);
        if (!frame_open) begin
            push_out(START_BYTE, 1'b0);
            frame_open = 1'b1;
            crc_acc    = '0;
            frames_sent++;
        end
        crc_acc = crc16_step(crc_acc, d);
        push_stuffed(d);
        if (l) begin
            push_stuffed(crc_acc[7:0]);
            push_stuffed(crc_acc[15:8]);
            push_out(ESC_BYTE, 1'b0);
            push_out(END_BYTE, 1'b1);
            crc_acc    = '0;
            frame_open = 1'b0;
        end
    endtask

    // ---------------- driver ----------------
    logic sink_hold = 1'b0;

    always @(posedge aclk) begin
        payload_beat_t nb;
        logic          burst;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                frame_encode(s_tdata, s_tlast);
                beats_sent++;
            end
            burst = sink_hold || (beats_sent >= 100 && beats_sent < 160);
            if (s_tvalid && !s_tready) begin
                // beat still pending, hold it
            end else if (pending_beats.size() > 0 &&
                         (burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nb = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nb.data;
                s_tlast  <= nb.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        framed_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_rx++;
                if (framed_bytes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected byte 0x%02h last=%0b", m_tdata, m_tlast);
                end else begin
                    want = framed_bytes.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: byte %0d exp 0x%02h/%0b got 0x%02h/%0b",
                                     bytes_rx, want.data, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready  <= 1'b0;
                sink_hold <= (hold_left > 1);
            end else if (!hold_done && bytes_rx >= STALL_AT_BYTE) begin
                hold_done = 1'b1;
                hold_left = STALL_CYCLES;
                m_tready  <= 1'b0;
                sink_hold <= 1'b1;
            end else begin
                m_tready <= (bytes_rx >= 150 && bytes_rx < 300) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------- watchdog ----------------
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("TIMEOUT: no beat moved for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_beat(input logic [7:0] d, input logic l);
        payload_beat_t pb;
        pb.data = d;
        pb.last = l;
        pending_beats.push_back(pb);
    endtask

    // two-byte frame whose CRC has the given byte in its low or high half
    task automatic queue_crc_pair(input logic [7:0] target, input bit hi_half);
        logic [15:0] c;
        logic [7:0]  fa, fbyte;
        bit          found;
        found = 1'b0;
        fa    = 8'h00;
        fbyte = 8'h00;
        for (int a = 0; a < 256 && !found; a++) begin
            for (int b = 0; b < 256 && !found; b++) begin
                c = crc16_step(crc16_step(16'h0000, a[7:0]), b[7:0]);
                if ((hi_half ? c[15:8] : c[7:0]) == target) begin
                    found = 1'b1;
                    fa    = a[7:0];
                    fbyte = b[7:0];
                end
            end
        end
        queue_beat(fa, 1'b0);
        queue_beat(fbyte, 1'b1);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] r;
        case ($urandom_range(0, 7))
            0: r = START_BYTE;
            1: r = ESC_BYTE;
            2: r = END_BYTE;
            default: r = 8'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    initial begin
        int n_len;
        int total;
        // single-byte frames at the extremes and on every special code
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b1);
        queue_beat(START_BYTE, 1'b1);
        queue_beat(ESC_BYTE, 1'b1);
        queue_beat(END_BYTE, 1'b1);
        // multi-byte frame with back-to-back stuffed bytes
        queue_beat(START_BYTE, 1'b0);
        queue_beat(ESC_BYTE, 1'b0);
        queue_beat(END_BYTE, 1'b0);
        queue_beat(8'hAA, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b1);
        // CRC bytes that need stuffing
        queue_crc_pair(START_BYTE, 1'b0);
        queue_crc_pair(ESC_BYTE, 1'b0);
        queue_crc_pair(START_BYTE, 1'b1);
        queue_crc_pair(ESC_BYTE, 1'b1);
        queue_beat(8'h01, 1'b0);
        queue_beat(8'h80, 1'b0);
        queue_beat(8'h7F, 1'b0);
        queue_beat(8'hFE, 1'b1);

        total = pending_beats.size();
        while (total < TARGET_BEATS) begin
            // mostly short frames, an occasional long one
            n_len = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 30)
                                                 : $urandom_range(1, 8);
            for (int i = 0; i < n_len; i++)
                queue_beat(pick_byte(), i == n_len - 1);
            total += n_len;
        end

        while (pending_beats.size() > 0 || s_tvalid) @(posedge aclk);
        while (framed_bytes.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d payload beats in %0d frames; checked %0d output bytes",
                 beats_sent, frames_sent, bytes_rx);
        $display("Stuffed bytes: %0d, sink stall of %0d cycles, mismatches: %0d",
                 stuffed_seen, STALL_CYCLES, errors);
        if (errors == 0 && framed_bytes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> crc16_byte_stuffed_frame_encoder.f
hw/rtl/crcfe_pkg.sv
hw/rtl/crcfe_emitter.sv
hw/rtl/crc16_byte_stuffed_frame_encoder.sv
hw/rtl/crcfe_checker.sv
tb/sv/crc16_byte_stuffed_frame_encoder_test.sv
